### rtl/assert_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/bpa_pkg.sv
// Package of shared codes for the buddy page allocator.
`default_nettype none
package bpa_pkg;
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;
  localparam int COUNT_W = 17;
endpackage
`default_nettype wire

### rtl/buddy_page_allocator.sv
// Buddy page allocator: sequencer around a free-list RAM and a pair-bit RAM.
// Alloc searches up for a non-empty list, pops a block and splits it down; a too-large request answers from idle.
// Free toggles the pair bit; if that clears it, scans the list for the buddy, merges and climbs; then pushes the block.
// Init clears the pair RAM, then pushes the top-order blocks into the top list and answers.
// One request at a time; stall_o is high while a request is in work or its result waits.
// Reset clears lengths, count and control, then clears the pair RAM.
`default_nettype none
`include "assert_macros.svh"
module buddy_page_allocator #(
  parameter int NUM_ORDERS = 11,
  parameter int PAGE_SHIFT = 12,
  parameter int FRAME_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [25:0] size_bytes_i,
  input  wire logic [27:0] free_address_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [1:0]       status_o,
  output logic [27:0]      block_address_o,
  output logic [10:0]      block_pages_o,
  output logic [16:0]      free_page_count_o
);
  localparam int FC   = 1 << FRAME_BITS;
  localparam int TOP  = NUM_ORDERS - 1;
  localparam int OW   = $clog2(NUM_ORDERS + 1);
  localparam int LAW  = FRAME_BITS + 1;          // list store address
  localparam int LW   = FRAME_BITS + 1;          // list length
  localparam int CW   = bpa_pkg::COUNT_W;
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_IPUSH, S_SEARCH, S_POPRD, S_POPWT, S_PTG, S_SPLIT,
    S_TGRD, S_TGWT, S_TGWR, S_SCANRD, S_SCANWT, S_SCANCHK, S_LASTWT,
    S_FPUSH, S_DONE
  } state_e;

  state_e state_q;
  logic [FRAME_BITS-1:0] start_q;
  logic [16:0] end_q;
  logic [FRAME_BITS-1:0] base_q;
  logic [LW-1:0] len_q [NUM_ORDERS];
  logic [CW-1:0] cnt_q;
  logic [1:0] op_q;
  logic [OW-1:0] ord_q, j_q, k_q;
  logic [FRAME_BITS-1:0] off_q, hit_q;
  logic [FRAME_BITS:0] cur_q, avail_q;
  logic [LW-1:0] i_q;
  logic [FRAME_BITS-1:0] clr_q;
  logic boot_q;
  logic in_split_q, ipair_q;
  logic [1:0] st_q;
  logic [27:0] addr_q;
  logic [10:0] pages_q;
  logic vo_q;

  // list RAM
  logic lwe; logic [LAW-1:0] lwa, lra; logic [FRAME_BITS-1:0] lwd, lrd;
  bpa_ram #(.Width(FRAME_BITS), .Depth(2*FC)) u_list (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd));
  // pair RAM
  logic pwe; logic [FRAME_BITS-1:0] pwa, pra; logic pwd, prd;
  bpa_ram #(.Width(1), .Depth(FC)) u_pair (
    .clk_i, .we_i(pwe), .waddr_i(pwa), .wdata_i(pwd), .raddr_i(pra), .rdata_o(prd));

  function automatic logic [LAW-1:0] lbase(input logic [OW-1:0] k);
    logic [LAW:0] t;
    t = (LAW+1)'(2*FC) - ((LAW+1)'(2*FC) >> k);
    return t[LAW-1:0];
  endfunction
  function automatic logic [LW-1:0] lcap(input logic [OW-1:0] k);
    logic [LW:0] t;
    t = (LW+1)'(FC) >> k;
    return t[LW-1:0];
  endfunction

  // pair index of block off at order k; valid when k < TOP
  logic [OW-1:0] pk; logic [FRAME_BITS-1:0] poff, pidx;
  always_comb begin
    logic [FRAME_BITS:0] t;
    t = (FRAME_BITS+1)'(FC) - ((FRAME_BITS+1)'(FC) >> pk)
        + (FRAME_BITS+1)'(poff >> (pk + OW'(1)));
    pidx = t[FRAME_BITS-1:0];
  end

  // size to order: pages = ceil(size/page), order = ceil log2
  logic [OW-1:0] sord; logic too_big;
  always_comb begin
    logic [26:0] pg;
    pg = (27'(size_bytes_i) + 27'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
    sord = '0; too_big = 1'b1;
    for (int o = 0; o < NUM_ORDERS; o++)
      if (too_big && pg <= 27'(1 << o)) begin
        sord = OW'(o); too_big = 1'b0;
      end
  end

  logic [FRAME_BITS-1:0] foff;
  always_comb begin
    logic [27:0] fr;
    fr = free_address_i >> PAGE_SHIFT;
    foff = FRAME_BITS'(fr) - base_q;
    foff = foff & ~FRAME_BITS'((1 << sord) - 1);
  end

  assign stall_o = (state_q != S_IDLE) || (vo_q && stall_i);
  assign valid_o = vo_q;
  assign status_o = st_q;
  assign block_address_o = addr_q;
  assign block_pages_o = pages_q;
  assign free_page_count_o = cnt_q;

  logic [FRAME_BITS-1:0] buddy;
  assign buddy = off_q ^ FRAME_BITS'(1 << k_q);

  always_comb begin
    lwe = 1'b0; lwa = '0; lwd = '0; lra = '0;
    pwe = 1'b0; pwa = '0; pwd = 1'b0; pra = '0;
    pk = k_q; poff = off_q;
    unique case (state_q)
      S_CLR: begin pwe = 1'b1; pwa = clr_q; end
      S_IPUSH: begin
        lwe = len_q[TOP] < lcap(OW'(TOP));
        lwa = lbase(OW'(TOP)) + LAW'(len_q[TOP]);
        lwd = FRAME_BITS'(cur_q) + (ipair_q ? FRAME_BITS'(1 << TOP) : '0);
      end
      S_POPRD: lra = lbase(j_q) + LAW'(len_q[j_q] - LW'(1));
      // keep the read address through the wait so the data lands in S_TGWR
      S_TGRD, S_TGWT: pra = pidx;
      S_TGWR: begin pwe = 1'b1; pwa = pidx; pwd = ~prd; end
      S_SPLIT: begin
        lwe = len_q[k_q] < lcap(k_q);
        lwa = lbase(k_q) + LAW'(len_q[k_q]);
        lwd = off_q + FRAME_BITS'(1 << k_q);
      end
      S_SCANRD, S_SCANWT: lra = lbase(k_q) + LAW'(i_q);
      S_LASTWT: lra = lbase(k_q) + LAW'(len_q[k_q] - LW'(1));
      S_FPUSH: begin
        lwe = len_q[k_q] < lcap(k_q);
        lwa = lbase(k_q) + LAW'(len_q[k_q]);
        lwd = off_q;
      end
      S_DONE: begin
        lwe = 1'b1; lwa = lbase(k_q) + LAW'(hit_q); lwd = lrd;
      end
      default: ;
    endcase
    if (in_split_q && (state_q == S_TGRD || state_q == S_TGWT || state_q == S_TGWR))
      poff = off_q + FRAME_BITS'(1 << k_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic vo_set;
    if (!rst_ni) begin
      // clear the pair RAM before the first request
      state_q <= S_CLR; clr_q <= '0; boot_q <= 1'b1;
      vo_q <= 1'b0; cnt_q <= '0;
      start_q <= '0; end_q <= '0; base_q <= '0;
      for (int o = 0; o < NUM_ORDERS; o++) len_q[o] <= '0;
      in_split_q <= 1'b0; ipair_q <= 1'b0;
    end else begin
      vo_set = 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == bpa_pkg::REG_START) start_q <= cfg_data_i[FRAME_BITS-1:0];
        else end_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: if (valid_i && !stall_o && operation_i != bpa_pkg::OP_NONE) begin
          op_q <= operation_i; ord_q <= sord; in_split_q <= 1'b0;
          if (operation_i == bpa_pkg::OP_INIT) begin
            logic [17:0] s, e;
            s = (18'(start_q) > 18'(FC)) ? 18'(FC) : 18'(start_q);
            e = (18'(end_q) > 18'(FC)) ? 18'(FC) : 18'(end_q);
            st_q <= bpa_pkg::ST_OK; addr_q <= '0; pages_q <= '0;
            base_q <= FRAME_BITS'(s);
            avail_q <= (e > s) ? (FRAME_BITS+1)'(e - s) : '0;
            for (int o = 0; o < NUM_ORDERS; o++) len_q[o] <= '0;
            cur_q <= '0; clr_q <= '0; ipair_q <= 1'b0;
            state_q <= S_CLR;
          end else if (too_big) begin
            st_q <= bpa_pkg::ST_TOO_BIG; addr_q <= '0; pages_q <= '0;
            vo_set = 1'b1;
          end else if (operation_i == bpa_pkg::OP_ALLOC) begin
            st_q <= bpa_pkg::ST_OK; addr_q <= '0; pages_q <= '0;
            j_q <= sord; state_q <= S_SEARCH;
          end else begin
            st_q <= bpa_pkg::ST_OK;
            off_q <= foff; k_q <= sord;
            addr_q <= 28'((32'(FRAME_BITS'(foff + base_q))) << PAGE_SHIFT);
            pages_q <= 11'(1 << sord);
            state_q <= (sord < OW'(TOP)) ? S_TGRD : S_FPUSH;
          end
        end
        S_CLR: begin
          clr_q <= clr_q + FRAME_BITS'(1);
          if (clr_q == FRAME_BITS'(FC - 1)) begin
            // after reset there is no request to answer
            boot_q <= 1'b0;
            state_q <= boot_q ? S_IDLE : S_IPUSH;
          end
        end
        S_IPUSH: begin
          if (!ipair_q && (avail_q - cur_q) <= (FRAME_BITS+1)'(2 << TOP)) begin
            cnt_q <= CW'(cur_q); vo_set = 1'b1; state_q <= S_IDLE;
          end else begin
            if (len_q[TOP] < lcap(OW'(TOP))) len_q[TOP] <= len_q[TOP] + LW'(1);
            ipair_q <= !ipair_q;
            if (ipair_q) cur_q <= cur_q + (FRAME_BITS+1)'(2 << TOP);
          end
        end
        S_SEARCH: begin
          if (j_q >= OW'(NUM_ORDERS)) begin
            st_q <= bpa_pkg::ST_NO_FREE; vo_set = 1'b1; state_q <= S_IDLE;
          end else if (len_q[j_q] == '0) j_q <= j_q + OW'(1);
          else state_q <= S_POPRD;
        end
        S_POPRD: begin
          len_q[j_q] <= len_q[j_q] - LW'(1); state_q <= S_POPWT;
        end
        S_POPWT: begin
          off_q <= lrd; k_q <= j_q;
          state_q <= (j_q < OW'(TOP)) ? S_TGRD : S_PTG;
        end
        S_PTG: begin
          if (k_q == ord_q) begin
            cnt_q <= (cnt_q < CW'(1 << ord_q)) ? '0 : cnt_q - CW'(1 << ord_q);
            addr_q <= 28'((32'(FRAME_BITS'(off_q + base_q))) << PAGE_SHIFT);
            pages_q <= 11'(1 << ord_q); vo_set = 1'b1; state_q <= S_IDLE;
          end else begin
            k_q <= k_q - OW'(1); state_q <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (len_q[k_q] < lcap(k_q)) len_q[k_q] <= len_q[k_q] + LW'(1);
          in_split_q <= 1'b1; state_q <= S_TGRD;
        end
        S_TGRD: state_q <= S_TGWT;
        S_TGWT: state_q <= S_TGWR;
        S_TGWR: begin
          if (op_q == bpa_pkg::OP_ALLOC) begin
            in_split_q <= 1'b0; state_q <= S_PTG;
          end else if (prd == 1'b0) state_q <= S_FPUSH;   // bit became one
          else begin i_q <= '0; state_q <= S_SCANRD; end
        end
        S_SCANRD: begin
          if (i_q >= len_q[k_q]) state_q <= S_FPUSH; else state_q <= S_SCANWT;
        end
        S_SCANWT: state_q <= S_SCANCHK;
        S_SCANCHK: begin
          if (lrd == buddy) begin
            hit_q <= FRAME_BITS'(i_q); state_q <= S_LASTWT;
          end else begin
            i_q <= i_q + LW'(1); state_q <= S_SCANRD;
          end
        end
        S_LASTWT: state_q <= S_DONE;
        S_DONE: begin
          // lrd holds last entry; write into hit slot, shrink, climb
          len_q[k_q] <= len_q[k_q] - LW'(1);
          off_q <= off_q & ~FRAME_BITS'(1 << k_q);
          k_q <= k_q + OW'(1);
          state_q <= (k_q + OW'(1) < OW'(TOP)) ? S_TGRD : S_FPUSH;
        end
        S_FPUSH: begin
          if (len_q[k_q] < lcap(k_q)) len_q[k_q] <= len_q[k_q] + LW'(1);
          cnt_q <= ((CW+1)'(cnt_q) + (CW+1)'(1 << ord_q) > (CW+1)'(CMAX)) ? CMAX
                   : cnt_q + CW'(1 << ord_q);
          vo_set = 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // raise a new result, else drop the one taken
      if (vo_set) vo_q <= 1'b1;
      else if (vo_q && !stall_i) vo_q <= 1'b0;
    end
  end

  `ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, state_q != S_IDLE, stall_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(block_address_o))
  `ASSERT_IMPL(a_status_ok, clk_i, rst_ni, valid_o && status_o != bpa_pkg::ST_OK, block_pages_o == '0)
endmodule
`default_nettype wire

### rtl/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module bpa_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [Width-1:0]   rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
